### hdl/ic3_pkg.sv
package ic3_pkg;

  localparam int ROW_W        = 12;
  localparam int COL_W        = 12;
  localparam int CH_W         = 2;
  localparam int NUM_WIN      = 4;
  localparam int PIX_W        = 8;
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CHAN_CFG_W   = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int OUT_COL_W    = 11;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CHAN_CFG_W-1:0]   CHAN_RESET   = 3'd3;
  localparam logic [HEIGHT_CFG_W-1:0] MAX_HEIGHT   = 13'd4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  ch;
    logic             emit;
    logic             last;
  } pos_t;

endpackage

### hdl/image_convolution_3x3_top.sv
// A sample taken is held in stage one; when stage one commits, its result is
// registered in the output stage. Throughput: one sample per cycle unless the
// output stalls; the line store is read when a sample is taken and written one
// stage later, the window commits in the same stage.
// Reset clears the raster counters, the window and all valid flags, and loads
// the default geometry. The line stores are not cleared.
module image_convolution_3x3_top import ic3_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIX_W-1:0]       sample,
  input  logic                   frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       filtered,
  output logic [ROW_W-1:0]       out_row,
  output logic [OUT_COL_W-1:0]   out_column,
  output logic [CH_W-1:0]        out_channel,
  output logic                   last
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LINE_W      = 2 * PIX_W;

  logic              accept;
  logic              s1_go;
  pos_t              pos;
  logic [ADDR_W-1:0] addr;

  logic              s1_valid;
  pos_t              s1_pos;
  pixel_t            s1_sample;
  logic [ADDR_W-1:0] s1_addr;

  logic [LINE_W-1:0] line_mem;
  logic              line_fwd;
  logic [LINE_W-1:0] line_fwd_data;
  logic [LINE_W-1:0] line_rd;
  pixel_t            up;
  pixel_t            mid;
  pixel_t            filter_sum;
  logic [COL_W-1:0]  col_m1;

  assign s1_go    = s1_valid && (!s1_pos.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;

  ic3_raster #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ADDR_W       (ADDR_W)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (frame_start),
    .pos         (pos),
    .addr        (addr)
  );

  // Each entry holds the upper line byte above the middle line byte.
  ic3_line_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (LINE_W)
  ) u_line_store (
    .clk   (clk),
    .write (s1_go),
    .waddr (s1_addr),
    .wdata ({mid, s1_sample}),
    .read  (accept),
    .raddr (addr),
    .rdata (line_mem)
  );

  // A read that meets the write of the previous sample at the same address
  // takes the word being written.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_fwd      <= s1_go && (addr == s1_addr);
      line_fwd_data <= {mid, s1_sample};
    end
  end

  assign line_rd = line_fwd ? line_fwd_data : line_mem;
  assign up      = line_rd[LINE_W-1:PIX_W];
  assign mid     = line_rd[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos    <= pos;
      s1_sample <= sample;
      s1_addr   <= addr;
    end
  end

  ic3_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .commit     (s1_go),
    .ch         (s1_pos.ch),
    .cur        (s1_sample),
    .up         (up),
    .mid        (mid),
    .filter_sum (filter_sum)
  );

  assign col_m1 = s1_pos.col - 12'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_pos.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_pos.emit) begin
      filtered    <= filter_sum;
      out_row     <= s1_pos.row - 12'd1;
      out_column  <= col_m1[OUT_COL_W-1:0];
      out_channel <= s1_pos.ch;
      last        <= s1_pos.last;
    end
  end

endmodule

### hdl/ic3_line_store.sv
module ic3_line_store #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              write,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              read,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (read) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ic3_raster.sv
module ic3_raster import ic3_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int ADDR_W       = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic                   frame_start,
  output pos_t                   pos,
  output logic [ADDR_W-1:0]      addr
);

  localparam int PROD_W = COL_W + CHAN_CFG_W;

  logic [WIDTH_CFG_W-1:0]  image_width;
  logic [HEIGHT_CFG_W-1:0] image_height;
  logic [CHAN_CFG_W-1:0]   channel_count;
  logic [ROW_W-1:0]        row_count;
  logic [COL_W-1:0]        column_count;
  logic [CH_W-1:0]         channel_index;
  logic [ROW_W-1:0]        row_count_next;
  logic [COL_W-1:0]        column_count_next;
  logic [CH_W-1:0]         channel_index_next;

  logic [WIDTH_CFG_W-1:0]  width_v;
  logic [HEIGHT_CFG_W-1:0] height_v;
  logic [CHAN_CFG_W-1:0]   chan_v;
  logic [WIDTH_CFG_W-1:0]  width_clamped;
  logic [HEIGHT_CFG_W-1:0] height_clamped;
  logic [CHAN_CFG_W-1:0]   chan_clamped;

  logic [ROW_W-1:0]        eff_row;
  logic [COL_W-1:0]        eff_col;
  logic [CH_W-1:0]         eff_ch;
  logic [CHAN_CFG_W-1:0]   ch_inc;
  logic [COL_W:0]          col_inc;
  logic [ROW_W:0]          row_inc;
  logic [PROD_W-1:0]       addr_full;

  assign width_v  = cfg_data[WIDTH_CFG_W-1:0];
  assign height_v = cfg_data[HEIGHT_CFG_W-1:0];
  assign chan_v   = cfg_data[CHAN_CFG_W-1:0];

  always_comb begin
    if (width_v < 12'd3) begin
      width_clamped = 12'd3;
    end else if (14'(width_v) > 14'(MAX_WIDTH)) begin
      width_clamped = 12'(MAX_WIDTH);
    end else begin
      width_clamped = width_v;
    end
    if (height_v < 13'd3) begin
      height_clamped = 13'd3;
    end else if (height_v > MAX_HEIGHT) begin
      height_clamped = MAX_HEIGHT;
    end else begin
      height_clamped = height_v;
    end
    if (chan_v < 3'd1) begin
      chan_clamped = 3'd1;
    end else if (chan_v > 3'(MAX_CHANNELS)) begin
      chan_clamped = 3'(MAX_CHANNELS);
    end else begin
      chan_clamped = chan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      channel_count <= CHAN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= width_clamped;
        REG_IMAGE_HEIGHT:  image_height  <= height_clamped;
        REG_CHANNEL_COUNT: channel_count <= chan_clamped;
        default: begin
        end
      endcase
    end
  end

  // A frame start restarts the raster position before the sample is placed.
  assign eff_row = frame_start ? '0 : row_count;
  assign eff_col = frame_start ? '0 : column_count;
  assign eff_ch  = frame_start ? '0 : channel_index;

  assign addr_full = PROD_W'(eff_col) * PROD_W'(channel_count) + PROD_W'(eff_ch);
  assign addr      = addr_full[ADDR_W-1:0];

  always_comb begin
    pos.row  = eff_row;
    pos.col  = eff_col;
    pos.ch   = eff_ch;
    pos.emit = (eff_row >= 12'd2) && (eff_col >= 12'd2);
    pos.last = ({1'b0, eff_row} == image_height - 13'd1) &&
               (eff_col == image_width - 12'd1) &&
               ({1'b0, eff_ch} == channel_count - 3'd1);
  end

  assign ch_inc  = {1'b0, eff_ch} + 3'd1;
  assign col_inc = {1'b0, eff_col} + 13'd1;
  assign row_inc = {1'b0, eff_row} + 13'd1;

  always_comb begin
    row_count_next     = eff_row;
    column_count_next  = eff_col;
    channel_index_next = ch_inc[CH_W-1:0];
    if (ch_inc >= channel_count) begin
      channel_index_next = '0;
      if (col_inc >= {1'b0, image_width}) begin
        column_count_next = '0;
        if (row_inc >= image_height) begin
          row_count_next = '0;
        end else begin
          row_count_next = row_inc[ROW_W-1:0];
        end
      end else begin
        column_count_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      column_count  <= '0;
      channel_index <= '0;
    end else if (accept) begin
      row_count     <= row_count_next;
      column_count  <= column_count_next;
      channel_index <= channel_index_next;
    end
  end

endmodule

### hdl/ic3_filter.sv
module ic3_filter import ic3_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            commit,
  input  logic [CH_W-1:0] ch,
  input  pixel_t          cur,
  input  pixel_t          up,
  input  pixel_t          mid,
  output pixel_t          filter_sum
);

  // Index order: channel, column (0 is two back, 1 is one back), row (upper, middle, lower).
  pixel_t win [NUM_WIN][2][3];

  pixel_t w00;
  pixel_t w01;
  pixel_t w02;
  pixel_t w10;
  pixel_t w12;
  logic [9:0] pos_sum;
  logic [9:0] neg_sum;
  logic [9:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        for (int j = 0; j < 2; j++) begin
          for (int r = 0; r < 3; r++) begin
            win[i][j][r] <= '0;
          end
        end
      end
    end else if (commit) begin
      win[ch][0][0] <= win[ch][1][0];
      win[ch][0][1] <= win[ch][1][1];
      win[ch][0][2] <= win[ch][1][2];
      win[ch][1][0] <= up;
      win[ch][1][1] <= mid;
      win[ch][1][2] <= cur;
    end
  end

  assign w00 = win[ch][0][0];
  assign w01 = win[ch][0][1];
  assign w02 = win[ch][0][2];
  assign w10 = win[ch][1][0];
  assign w12 = win[ch][1][2];

  assign pos_sum = 10'(w10) + 10'(w01) + 10'(mid) + 10'(w12);
  assign neg_sum = 10'(w00) + 10'(up) + 10'(w02) + 10'(cur);
  assign diff    = pos_sum - neg_sum;

  always_comb begin
    if (neg_sum >= pos_sum) begin
      filter_sum = '0;
    end else if (diff > 10'd255) begin
      filter_sum = 8'd255;
    end else begin
      filter_sum = diff[PIX_W-1:0];
    end
  end

endmodule
